FILE: hdl/dbcm_pkg.sv
// ----------------------------------------------------------------------------
// dbcm_pkg
// Shared types and constants for the depth band cross mask filter.
// ----------------------------------------------------------------------------
package dbcm_pkg;

    localparam int DEPTH_W    = 16;
    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // smallest frame dimension the stencil works on
    localparam int MIN_FRAME_DIM = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DEPTH    = 3'd0,
        CFG_MAX_DEPTH    = 3'd1,
        CFG_NOISE_TOL    = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH    = 16'd500;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH    = 16'd1000;
    localparam logic [DEPTH_W-1:0] RST_NOISE_TOL    = 16'd10;
    localparam logic [X_W-1:0]     RST_FRAME_WIDTH  = 10'd640;
    localparam logic [Y_W-1:0]     RST_FRAME_HEIGHT = 9'd480;

    // configuration with frame size already clamped
    typedef struct packed {
        logic [DEPTH_W-1:0] depth_lo;
        logic [DEPTH_W-1:0] depth_hi;
        logic [DEPTH_W-1:0] noise_tol;
        logic [X_W-1:0]     frame_w;
        logic [Y_W-1:0]     frame_h;
    } t_cfg;

    typedef struct packed {
        logic [X_W-1:0] px;
        logic [Y_W-1:0] py;
    } t_pos;

endpackage

FILE: hdl/dbcm_pix_if.sv
// ----------------------------------------------------------------------------
// dbcm_pix_if
// Pixel input channel: valid/ready with depth sample and frame start flag.
// ----------------------------------------------------------------------------
interface dbcm_pix_if;
    import dbcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth;
    logic               frame_start;

    modport source (output valid, output depth, output frame_start, input ready);
    modport sink   (input valid, input depth, input frame_start, output ready);
endinterface

FILE: hdl/dbcm_res_if.sv
// ----------------------------------------------------------------------------
// dbcm_res_if
// Result channel: valid/ready with masked depth and pixel position.
// ----------------------------------------------------------------------------
interface dbcm_res_if;
    import dbcm_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] mask_depth;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;

    modport source (output valid, output mask_depth, output pixel_x, output pixel_y,
                    input ready);
    modport sink   (input valid, input mask_depth, input pixel_x, input pixel_y,
                    output ready);
endinterface

FILE: hdl/dbcm_cfg.sv
// ----------------------------------------------------------------------------
// dbcm_cfg
// Configuration registers; frame size is clamped to the supported range.
// ----------------------------------------------------------------------------
module dbcm_cfg #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dbcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbcm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dbcm_pkg::t_cfg                  o_cfg
);
    import dbcm_pkg::*;

    logic [DEPTH_W-1:0] r_depth_lo;
    logic [DEPTH_W-1:0] r_depth_hi;
    logic [DEPTH_W-1:0] r_noise_tol;
    logic [X_W-1:0]     r_frame_w;
    logic [Y_W-1:0]     r_frame_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_lo  <= RST_MIN_DEPTH;
            r_depth_hi  <= RST_MAX_DEPTH;
            r_noise_tol <= RST_NOISE_TOL;
            r_frame_w   <= RST_FRAME_WIDTH;
            r_frame_h   <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_DEPTH:    r_depth_lo  <= i_cfg_data[DEPTH_W-1:0];
                CFG_MAX_DEPTH:    r_depth_hi  <= i_cfg_data[DEPTH_W-1:0];
                CFG_NOISE_TOL:    r_noise_tol <= i_cfg_data[DEPTH_W-1:0];
                CFG_FRAME_WIDTH:  r_frame_w   <= i_cfg_data[X_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_h   <= i_cfg_data[Y_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.depth_lo  = r_depth_lo;
        o_cfg.depth_hi  = r_depth_hi;
        o_cfg.noise_tol = r_noise_tol;

        if (32'(r_frame_w) < 32'(MIN_FRAME_DIM)) begin
            o_cfg.frame_w = X_W'(MIN_FRAME_DIM);
        end else if (32'(r_frame_w) > 32'(MAX_WIDTH)) begin
            o_cfg.frame_w = X_W'(MAX_WIDTH);
        end else begin
            o_cfg.frame_w = r_frame_w;
        end

        if (32'(r_frame_h) < 32'(MIN_FRAME_DIM)) begin
            o_cfg.frame_h = Y_W'(MIN_FRAME_DIM);
        end else if (32'(r_frame_h) > 32'(MAX_HEIGHT)) begin
            o_cfg.frame_h = Y_W'(MAX_HEIGHT);
        end else begin
            o_cfg.frame_h = r_frame_h;
        end
    end

endmodule

FILE: hdl/dbcm_line_store.sv
// ----------------------------------------------------------------------------
// dbcm_line_store
// Two-row line store, one word per column holding {row r-2, row r-1}.
// Registered read with write-first bypass on a same-column collision.
// ----------------------------------------------------------------------------
module dbcm_line_store #(
    parameter int SW        = 16,
    parameter int MAX_WIDTH = 640,
    parameter int AW        = 10
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [2*SW-1:0] i_wr_data,
    output logic [2*SW-1:0] o_rd_data
);
    logic [2*SW-1:0] mem [MAX_WIDTH];
    logic [2*SW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/dbcm_stencil.sv
// ----------------------------------------------------------------------------
// dbcm_stencil
// Cross window registers, band and neighbor test, and the output register.
// ----------------------------------------------------------------------------
module dbcm_stencil #(
    parameter int SW = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dbcm_pkg::t_cfg  i_cfg,
    input  logic            i_s1_valid,
    input  dbcm_pkg::t_pos  i_s1_pos,
    input  logic [SW-1:0]   i_s1_pix,
    input  logic [2*SW-1:0] i_rd_data,
    output logic            o_advance,
    dbcm_res_if.source      o_res
);
    import dbcm_pkg::*;

    localparam logic [2:0] NEAR_LO = 3'd2;
    localparam logic [2:0] NEAR_HI = 3'd3;

    logic [SW-1:0]      r_above;
    logic [SW-1:0]      r_ctr;
    logic [SW-1:0]      r_left;
    logic [SW-1:0]      r_below;
    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_mask;
    t_pos               r_pos;

    logic [SW-1:0]      rd_top;
    logic [SW-1:0]      rd_right;
    logic [2:0]         near_cnt;
    logic               in_band;
    logic               inner;
    logic               keep;
    logic [DEPTH_W-1:0] n_mask;

    function automatic logic is_near(input logic [SW-1:0]      nb,
                                     input logic [SW-1:0]      ctr,
                                     input logic [DEPTH_W-1:0] tol);
        logic [SW-1:0] diff;
        diff = (nb > ctr) ? (nb - ctr) : (ctr - nb);
        return DEPTH_W'(diff) < tol;
    endfunction

    always_comb begin
        rd_top   = i_rd_data[2*SW-1:SW];
        rd_right = i_rd_data[SW-1:0];

        near_cnt = {2'b00, is_near(r_below, r_ctr, i_cfg.noise_tol)}
                 + {2'b00, is_near(r_above, r_ctr, i_cfg.noise_tol)}
                 + {2'b00, is_near(r_left,  r_ctr, i_cfg.noise_tol)}
                 + {2'b00, is_near(rd_right, r_ctr, i_cfg.noise_tol)};

        in_band = (r_ctr != '0)
               && (DEPTH_W'(r_ctr) < i_cfg.depth_hi)
               && (DEPTH_W'(r_ctr) > i_cfg.depth_lo);

        inner = (i_s1_pos.px != '0) && (i_s1_pos.px != i_cfg.frame_w - 1'b1)
             && (i_s1_pos.py != '0) && (i_s1_pos.py != i_cfg.frame_h - 1'b1);

        keep   = in_band && inner && ((near_cnt == NEAR_LO) || (near_cnt == NEAR_HI));
        n_mask = keep ? DEPTH_W'(r_ctr) : '0;
    end

    assign o_advance = i_s1_valid && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // slide the window one column and load the result
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_above <= rd_top;
            r_left  <= r_ctr;
            r_ctr   <= rd_right;
            r_below <= i_s1_pix;
            r_mask  <= n_mask;
            r_pos   <= i_s1_pos;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.mask_depth = r_mask;
    assign o_res.pixel_x    = r_pos.px;
    assign o_res.pixel_y    = r_pos.py;

endmodule

FILE: hdl/depth_band_cross_mask.sv
// ----------------------------------------------------------------------------
// depth_band_cross_mask
// Pipeline: an accepted beat waits in stage 1, then the stencil registers its result onto o_res.
// Throughput: one pixel beat per cycle while o_res is not stalled; the line
// store takes one read on each accept and one write on each stencil advance.
// Reset: clears counters and valid flags and loads the default configuration;
// the line store and window are not cleared, since stale values only feed
// border results that are zero.
// ----------------------------------------------------------------------------
module depth_band_cross_mask #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480,
    parameter int DEPTH_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dbcm_pix_if.sink                        i_pix,
    dbcm_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [dbcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dbcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dbcm_pkg::*;

    // stored sample width: the input field never carries more than DEPTH_W bits
    localparam int SW = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_cfg            cfg;
    logic            accept;
    logic            advance;

    logic [X_W-1:0]  r_col;
    logic [Y_W-1:0]  r_row;
    logic [X_W-1:0]  cur_col;
    logic [Y_W-1:0]  cur_row;
    logic [X_W-1:0]  n_col;
    logic [Y_W-1:0]  n_row;
    t_pos            cur_pos;

    // stage 1: pixel waiting for its line store read
    logic            r_s1_valid;
    t_pos            r_s1_pos;
    logic [SW-1:0]   r_s1_pix;
    logic [X_W-1:0]  r_s1_col;

    logic [2*SW-1:0] rd_data;
    logic [2*SW-1:0] wr_data;

    dbcm_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Take the next beat whenever stage 1 is empty or draining this cycle;
    // stage 1 drains whenever the stencil's output register is free or
    // being emptied, so input stalls only while a result waits.
    assign i_pix.ready = !r_s1_valid || advance;
    assign accept      = i_pix.valid && i_pix.ready;

    // Position of the incoming pixel and of the pixel its result refers to
    // (one row up and one column left, raster order wraps into the last
    // column two rows up, and past row 0 into the previous frame).
    always_comb begin
        cur_col = i_pix.frame_start ? '0 : r_col;
        cur_row = i_pix.frame_start ? '0 : r_row;
        // counters can sit past the frame after a size change: wrap them
        if (cur_col >= cfg.frame_w) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end
        if (cur_row >= cfg.frame_h) begin
            cur_row = '0;
        end

        if (cur_col != '0) begin
            cur_pos.px = cur_col - 1'b1;
            cur_pos.py = (cur_row != '0) ? (cur_row - 1'b1) : (cfg.frame_h - 1'b1);
        end else begin
            cur_pos.px = cfg.frame_w - 1'b1;
            cur_pos.py = (cur_row >= Y_W'(2)) ? (cur_row - Y_W'(2))
                                              : (cfg.frame_h - Y_W'(2) + cur_row);
        end

        // advance to the next raster position
        n_col = cur_col + 1'b1;
        n_row = cur_row;
        if (n_col >= cfg.frame_w) begin
            n_col = '0;
            n_row = cur_row + 1'b1;
            if (n_row >= cfg.frame_h) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // hold the beat's payload until the stencil consumes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= cur_pos;
            r_s1_pix <= i_pix.depth[SW-1:0];
            r_s1_col <= cur_col;
        end
    end

    // Read {row r-2, row r-1} of this column on accept; when the pixel moves
    // into the stencil, write back {row r-1, row r}, shifting the column down.
    assign wr_data = {rd_data[SW-1:0], r_s1_pix};

    dbcm_line_store #(
        .SW        (SW),
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(cur_col)),
        .i_wr_en   (advance),
        .i_wr_addr (AW'(r_s1_col)),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Cross test on the window; the fresh row r-1 sample is the right
    // neighbor, the window holds above, center, left and below.
    dbcm_stencil #(
        .SW (SW)
    ) u_stencil (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (r_s1_valid),
        .i_s1_pos   (r_s1_pos),
        .i_s1_pix   (r_s1_pix),
        .i_rd_data  (rd_data),
        .o_advance  (advance),
        .o_res      (o_res)
    );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for depth_band_cross_mask. Streams raster depth frames
// into the pixel channel and keeps a local copy of the line stores, stencil
// window and position counters. From that copy it works out the mask beat
// that each pixel beat should produce. Every result beat is checked in order
// against those predictions; in most tests the channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbcm_pkg::*;

    localparam int MAX_W       = 640;
    localparam int MAX_H       = 480;
    localparam int STALL_LIMIT = 2000;   // cycles without any beat before giving up
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic [DEPTH_W-1:0] mask_depth;
        logic [X_W-1:0]     pixel_x;
        logic [Y_W-1:0]     pixel_y;
    } t_mask_beat;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // Hand-made 5x4 frame in raster order. Interior pixels hit three, two and
    // one similar cross neighbours, a zero depth, and both exclusive band edges.
    localparam logic [0:19][DEPTH_W-1:0] CROSS_FRAME = {
        16'd150, 16'd150, 16'd160, 16'd150, 16'd150,
        16'd150, 16'd150, 16'd159, 16'd101, 16'd199,
        16'd150, 16'd0,   16'd200, 16'd100, 16'd150,
        16'd140, 16'd150, 16'd150, 16'd141, 16'd150
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dbcm_pix_if pix_bus ();
    dbcm_res_if res_bus ();

    depth_band_cross_mask #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .DEPTH_BITS (DEPTH_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_bus),
        .o_res      (res_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the register file, updated when a write is driven. Writes only
    // happen while the pixel channel is quiet, so no beat ever sees a half-done
    // update.
    logic [DEPTH_W-1:0] cfg_min;
    logic [DEPTH_W-1:0] cfg_max;
    logic [DEPTH_W-1:0] cfg_tol;
    logic [X_W-1:0]     cfg_w;
    logic [Y_W-1:0]     cfg_h;

    // Local copy of the filter state: line store (row r-1 in the low half,
    // row r-2 in the high half), the stencil registers and the raster counters.
    logic [DEPTH_W-1:0] line_mem [2*MAX_W];
    logic [DEPTH_W-1:0] win_above;
    logic [DEPTH_W-1:0] win_ctr;
    logic [DEPTH_W-1:0] win_left;
    logic [DEPTH_W-1:0] win_below;
    int unsigned        col_cnt;
    int unsigned        row_cnt;

    t_mask_beat  pending_mask [$];
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < MIN_FRAME_DIM) return MIN_FRAME_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int similar(input logic [DEPTH_W-1:0] nb,
                                   input logic [DEPTH_W-1:0] ctr);
        logic [DEPTH_W-1:0] diff;
        diff = (nb > ctr) ? nb - ctr : ctr - nb;
        return (diff < cfg_tol) ? 1 : 0;
    endfunction

    // Advance the local filter by one pixel beat and queue the mask beat it
    // produces. The result pixel sits W+1 positions behind the input.
    task automatic predict_mask(input logic [DEPTH_W-1:0] depth, input logic start);
        int unsigned        w, h, c, r, px, py, n;
        logic [DEPTH_W-1:0] top, mid, kept;
        t_mask_beat         beat;
        w = clamp_dim(cfg_w, MAX_W);
        h = clamp_dim(cfg_h, MAX_H);
        if (start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // counters may sit past the frame after a size change: wrap them first
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        c   = col_cnt;
        r   = row_cnt;
        top = line_mem[MAX_W + c];
        mid = line_mem[c];
        if (c >= 1) begin
            px = c - 1;
            py = (r >= 1) ? r - 1 : h - 1;
        end else begin
            px = w - 1;
            py = (r >= 2) ? r - 2 : h - 2 + r;
        end
        kept = '0;
        if (win_ctr != 0 && win_ctr < cfg_max && win_ctr > cfg_min &&
            px != 0 && px != w - 1 && py != 0 && py != h - 1) begin
            n = similar(win_below, win_ctr) + similar(win_above, win_ctr) +
                similar(win_left, win_ctr) + similar(mid, win_ctr);
            if (n == 2 || n == 3) kept = win_ctr;
        end
        win_above          = top;
        win_left           = win_ctr;
        win_ctr            = mid;
        win_below          = depth;
        line_mem[MAX_W + c] = mid;
        line_mem[c]         = depth;
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        beat.mask_depth = kept;
        beat.pixel_x    = X_W'(px);
        beat.pixel_y    = Y_W'(py);
        pending_mask.insert(pending_mask.size(), beat);
    endtask

    // ------------------------------------------------------------------------
    // Checking: compare each result beat with the oldest prediction, then
    // advance the prediction on each pixel beat taken at the same edge.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : check_beats
        t_mask_beat got;
        t_mask_beat want;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                got.mask_depth = res_bus.mask_depth;
                got.pixel_x    = res_bus.pixel_x;
                got.pixel_y    = res_bus.pixel_y;
                if (pending_mask.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat depth=%0d x=%0d y=%0d",
                                              got.mask_depth, got.pixel_x, got.pixel_y));
                end else begin
                    want = pending_mask.pop_front();
                    if (got.mask_depth !== want.mask_depth)
                        report_mismatch($sformatf("mask_depth %0d, want %0d at x=%0d y=%0d",
                                                  got.mask_depth, want.mask_depth,
                                                  want.pixel_x, want.pixel_y));
                    if (got.pixel_x !== want.pixel_x)
                        report_mismatch($sformatf("pixel_x %0d, want %0d",
                                                  got.pixel_x, want.pixel_x));
                    if (got.pixel_y !== want.pixel_y)
                        report_mismatch($sformatf("pixel_y %0d, want %0d",
                                                  got.pixel_y, want.pixel_y));
                end
            end
            if (pix_bus.valid && pix_bus.ready)
                predict_mask(pix_bus.depth, pix_bus.frame_start);
        end
    end

    // Give up when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && !(pix_bus.valid && pix_bus.ready) &&
            !(res_bus.valid && res_bus.ready)) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // Receiver backpressure: drop ready in stall_pct cycles of a hundred.
    always @(posedge i_clk) begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                gap_pct   = 67;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct   = 0;
                stall_pct = 67;
            end
            default: begin
                gap_pct   = 26;
                stall_pct = 26;
            end
        endcase
    endtask

    // Drive one register write; the enable stays high for the caller to lower.
    task automatic drive_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_MIN_DEPTH:    cfg_min = DEPTH_W'(val);
            CFG_MAX_DEPTH:    cfg_max = DEPTH_W'(val);
            CFG_NOISE_TOL:    cfg_tol = DEPTH_W'(val);
            CFG_FRAME_WIDTH:  cfg_w   = X_W'(val);
            CFG_FRAME_HEIGHT: cfg_h   = Y_W'(val);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Write the whole register file back to back; call only while idle.
    task automatic set_config(input int unsigned lo, input int unsigned hi,
                              input int unsigned tol, input int unsigned w,
                              input int unsigned h);
        drive_reg(CFG_MIN_DEPTH, lo);
        drive_reg(CFG_MAX_DEPTH, hi);
        drive_reg(CFG_NOISE_TOL, tol);
        drive_reg(CFG_FRAME_WIDTH, w);
        drive_reg(CFG_FRAME_HEIGHT, h);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one pixel beat after a random idle gap and hold it until taken.
    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic start);
        int unsigned gap;
        gap = 0;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) gap++;
        if (gap != 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.depth       <= depth;
        pix_bus.frame_start <= start;
        do @(posedge i_clk); while (!pix_bus.ready);
    endtask

    // Hold the sender until every predicted beat has come back, then let the
    // pipeline settle.
    task automatic wait_for_results();
        pix_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_mask.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly depths near base, with holes and wild samples mixed in.
    function automatic logic [DEPTH_W-1:0] pick_depth(input int unsigned base,
                                                      input int unsigned spread);
        int unsigned k;
        int          v;
        k = $urandom_range(99);
        if (k < 8) return '0;
        if (k < 16) return DEPTH_W'($urandom);
        v = int'(base) + int'($urandom_range(2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return DEPTH_W'(v);
    endfunction

    task automatic send_frame(input int unsigned n_px, input bit with_start,
                              input int unsigned base, input int unsigned spread);
        for (int unsigned i = 0; i < n_px; i++)
            send_pixel(pick_depth(base, spread), with_start && i == 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Default registers straight out of reset: early beats, depth extremes,
    // and a frame start that lands in the middle of the first row.
    task automatic test_after_reset();
        set_idling(IDLE_NONE);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hAAAA, 1'b1);
        send_pixel(16'h5555, 1'b0);
        wait_for_results();
    endtask

    // Hand-made frame, then the early beats of the next frame, which cover
    // the bottom row of this one.
    task automatic test_cross_stencil();
        set_idling(IDLE_NONE);
        set_config(100, 200, 10, 5, 4);
        for (int i = 0; i < 20; i++)
            send_pixel(CROSS_FRAME[i], i == 0);
        send_frame(6, 1'b1, 150, 5);
        wait_for_results();
    endtask

    // Frame sizes below the minimum and above the line store, plus the full
    // width and full height extremes.
    task automatic test_size_clamp();
        set_idling(IDLE_NONE);
        set_config(100, 60000, 30, 0, 1);
        send_frame(9, 1'b1, 5000, 30);
        send_frame(18, 1'b0, 5000, 30);
        wait_for_results();
        set_idling(IDLE_BOTH);
        set_config(100, 60000, 30, 1023, 0);
        send_frame(MAX_W + 8, 1'b1, 5000, 30);
        wait_for_results();
        set_idling(IDLE_SENDER);
        set_config(100, 60000, 30, 3, MAX_H);
        send_frame(3 * 10, 1'b1, 5000, 30);
        wait_for_results();
        set_idling(IDLE_RECEIVER);
        set_config(100, 60000, 30, 2, 511);
        send_frame(40, 1'b1, 5000, 30);
        wait_for_results();
    endtask

    // Stop mid-frame, then shrink both sizes so the counters sit past the new
    // frame; carry on without any frame start so they must wrap by themselves.
    task automatic test_counter_wrap();
        set_idling(IDLE_RECEIVER);
        set_config(1000, 3000, 20, 12, 10);
        send_frame(12 * 10 + 12 * 8 + 9, 1'b1, 2000, 20);
        wait_for_results();
        set_config(1000, 3000, 20, 5, 4);
        send_frame(5 * 4 * 3, 1'b0, 2000, 20);
        wait_for_results();
    endtask

    // Empty and inverted bands, tolerance extremes, and the widest band.
    task automatic test_band_edges();
        int unsigned lo, hi, tol, base;
        for (int k = 0; k < 7; k++) begin
            case (k)
                0: begin lo = 1000;  hi = 1001;  tol = 10;    base = 1000;  end
                1: begin lo = 700;   hi = 300;   tol = 10;    base = 500;   end
                2: begin lo = 600;   hi = 600;   tol = 10;    base = 600;   end
                3: begin lo = 0;     hi = 65535; tol = 0;     base = 30000; end
                4: begin lo = 0;     hi = 65535; tol = 65535; base = 30000; end
                5: begin lo = 65535; hi = 0;     tol = 10;    base = 30000; end
                default: begin lo = 1; hi = 65535; tol = 10; base = 1000; end
            endcase
            set_idling(t_idle_mode'(k % 4));
            set_config(lo, hi, tol, 4, 4);
            send_frame(20, 1'b1, base, 10);
            wait_for_results();
        end
    endtask

    // Random registers and frames: mostly well-formed frames with random
    // content, some cut short, some without a frame start, and a few phases
    // of pure noise with stray frame starts.
    task automatic test_random_frames();
        int unsigned lo, hi, tol, w, h, base, n_px, sent;
        bit          noisy, with_start;
        for (int ph = 0; ph < 8; ph++) begin
            set_idling(t_idle_mode'(ph % 4));
            lo  = $urandom_range(30000, 1);
            hi  = lo + $urandom_range(3000, 2);
            tol = $urandom_range(60, 1);
            w   = $urandom_range(20, 3);
            h   = $urandom_range(12, 3);
            set_config(lo, hi, tol, w, h);
            noisy = ($urandom_range(7) == 0);
            sent  = 0;
            while (sent < 40) begin
                n_px = w * h;
                if ($urandom_range(9) == 0) n_px = $urandom_range(n_px, 1);
                with_start = (sent == 0) || ($urandom_range(3) != 0);
                if (noisy) begin
                    for (int unsigned i = 0; i < n_px; i++)
                        send_pixel(DEPTH_W'($urandom),
                                   (sent == 0 && i == 0) || $urandom_range(19) == 0);
                end else begin
                    base = $urandom_range(hi - 1, lo + 1);
                    send_frame(n_px, with_start, base, tol);
                end
                sent += n_px;
                // hold the sender off until the pipe has fully drained
                if (ph == 0 || $urandom_range(5) == 0) wait_for_results();
            end
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_MIN_DEPTH;
        i_cfg_data          = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.depth       = '0;
        pix_bus.frame_start = 1'b0;
        res_bus.ready       = 1'b1;
        cfg_min   = RST_MIN_DEPTH;
        cfg_max   = RST_MAX_DEPTH;
        cfg_tol   = RST_NOISE_TOL;
        cfg_w     = RST_FRAME_WIDTH;
        cfg_h     = RST_FRAME_HEIGHT;
        win_above = '0;
        win_ctr   = '0;
        win_left  = '0;
        win_below = '0;
        col_cnt   = 0;
        row_cnt   = 0;
        foreach (line_mem[i]) line_mem[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_cross_stencil();
        test_size_clamp();
        test_counter_wrap();
        test_band_edges();
        test_random_frames();

        // drain, then leave room for any stray beat to show up
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
